[sv/pes_header_timestamp_parser_unit_defines.svh]
// Assertion macros shared by the PES header timestamp parser.
`ifndef PES_HEADER_TIMESTAMP_PARSER_UNIT_DEFINES_SVH
`define PES_HEADER_TIMESTAMP_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PES_HDR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PES_HDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pes_hdr_pkg.sv]
// Types, codes and helper functions shared by the PES header parser modules.
`default_nettype none
package pes_hdr_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_TS     = 3'd1;
  localparam logic [2:0] ST_BAD_MARK  = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic [1:0] FLAGS_PTS_DTS = 2'b11;
  localparam logic [1:0] FLAGS_PTS     = 2'b10;
  localparam logic [1:0] MARKER_OK     = 2'b10;

  localparam logic [8:0] HL_MIN_PTS_DTS = 9'd13;
  localparam logic [8:0] HL_MIN_PTS     = 9'd8;
  localparam logic [8:0] HL_BIAS        = 9'd3;

  localparam logic [3:0] POS_NONE    = 4'd15;
  localparam logic [3:0] POS_DTS     = 4'd5;
  localparam logic [3:0] POS_END     = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [32:0] pts_value;
    logic [32:0] dts_value;
    logic [8:0]  header_length;
  } out_beat_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_FLAGS,
    OP_BODY
  } op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_BAD,
    EMIT_TRUNC,
    EMIT_FINISH
  } emit_t;

  typedef struct packed {
    op_t        op;
    emit_t      emit;
    logic [7:0] data;
    logic [3:0] pos;
    logic [8:0] hl;
  } cmd_t;

  function automatic logic [32:0] ts_piece(input logic [2:0] pos, input logic [7:0] b);
    logic [32:0] r;
    case (pos)
      3'd0:    r = {b[3:1], 30'b0};
      3'd1:    r = {3'b0, b, 22'b0};
      3'd2:    r = {11'b0, b[7:1], 15'b0};
      3'd3:    r = {18'b0, b, 7'b0};
      3'd4:    r = {26'b0, b[7:1]};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/pes_hdr_front.sv]
// Front end: tracks the header position of each byte and turns it into a command.
`default_nettype none
module pes_hdr_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     accept,
  input  pes_hdr_pkg::in_beat_t   in_data,
  output logic                    cmd_valid,
  output pes_hdr_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FLAGS,
    PH_HLEN,
    PH_BODY
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] dlen_r, dlen_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  always_comb begin
    phase_nxt = phase_r;
    dlen_nxt  = dlen_r;
    cnt_nxt   = cnt_r;
    cmd_valid = 1'b0;
    cmd.op    = pes_hdr_pkg::OP_NONE;
    cmd.emit  = pes_hdr_pkg::EMIT_NONE;
    cmd.data  = in_data.data_byte;
    cmd.pos   = pes_hdr_pkg::POS_NONE;
    cmd.hl    = '0;
    if (in_data.first_byte) begin
      cmd_valid = 1'b1;
      cmd.op    = pes_hdr_pkg::OP_START;
      dlen_nxt  = '0;
      cnt_nxt   = '0;
      if (in_data.data_byte[7:6] != pes_hdr_pkg::MARKER_OK) begin
        cmd.emit  = pes_hdr_pkg::EMIT_BAD;
        phase_nxt = PH_IDLE;
      end else if (in_data.last_byte) begin
        cmd.emit  = pes_hdr_pkg::EMIT_TRUNC;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = PH_FLAGS;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          cmd_valid = 1'b0;
        end
        PH_FLAGS: begin
          cmd_valid = 1'b1;
          cmd.op    = pes_hdr_pkg::OP_FLAGS;
          if (in_data.last_byte) begin
            cmd.emit  = pes_hdr_pkg::EMIT_TRUNC;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_HLEN;
          end
        end
        PH_HLEN: begin
          cmd_valid = 1'b1;
          dlen_nxt  = in_data.data_byte;
          cnt_nxt   = '0;
          cmd.hl    = {1'b0, in_data.data_byte} + pes_hdr_pkg::HL_BIAS;
          if (in_data.data_byte == 8'd0) begin
            cmd.emit  = pes_hdr_pkg::EMIT_FINISH;
            phase_nxt = PH_IDLE;
          end else if (in_data.last_byte) begin
            cmd.emit  = pes_hdr_pkg::EMIT_TRUNC;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          cmd_valid = 1'b1;
          cmd.op    = pes_hdr_pkg::OP_BODY;
          cmd.hl    = {1'b0, dlen_r} + pes_hdr_pkg::HL_BIAS;
          if (cnt_r < {4'b0, pes_hdr_pkg::POS_END}) begin
            cmd.pos = cnt_r[3:0];
          end
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt == dlen_r) begin
            cmd.emit  = pes_hdr_pkg::EMIT_FINISH;
            phase_nxt = PH_IDLE;
          end else if (in_data.last_byte) begin
            cmd.emit  = pes_hdr_pkg::EMIT_TRUNC;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dlen_r  <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      dlen_r  <= dlen_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/pes_hdr_cmd_fifo.sv]
// Short command queue between the front end and the back end.
`default_nettype none
module pes_hdr_cmd_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  pes_hdr_pkg::cmd_t   push_cmd,
  input  wire                 pop,
  output logic                full,
  output logic                empty,
  output pes_hdr_pkg::cmd_t   head_cmd
);

  pes_hdr_pkg::cmd_t              mem_r [pes_hdr_pkg::QDEPTH];
  logic [pes_hdr_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pes_hdr_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pes_hdr_pkg::QAW:0]      count_r, count_nxt;

  assign full     = (count_r == (pes_hdr_pkg::QAW+1)'(pes_hdr_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/pes_hdr_back.sv]
// Back end: assembles the timestamps and drives the result register.
`default_nettype none
module pes_hdr_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     q_empty,
  input  pes_hdr_pkg::cmd_t       q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_stall,
  output pes_hdr_pkg::out_beat_t  out_data
);

  logic [1:0]              flags_r, flags_nxt;
  logic [32:0]             pts_r, pts_nxt;
  logic [32:0]             dts_r, dts_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pes_hdr_pkg::out_beat_t  out_data_r, out_data_nxt;
  logic                    slot_free;
  logic [3:0]              dts_pos;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = !q_empty && ((q_cmd.emit == pes_hdr_pkg::EMIT_NONE) || slot_free);
  assign dts_pos   = q_cmd.pos - pes_hdr_pkg::POS_DTS;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    flags_nxt     = flags_r;
    pts_nxt       = pts_r;
    dts_nxt       = dts_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      case (q_cmd.op)
        pes_hdr_pkg::OP_START: begin
          flags_nxt = '0;
          pts_nxt   = '0;
          dts_nxt   = '0;
        end
        pes_hdr_pkg::OP_FLAGS: begin
          flags_nxt = q_cmd.data[7:6];
        end
        pes_hdr_pkg::OP_BODY: begin
          if (q_cmd.pos < pes_hdr_pkg::POS_DTS) begin
            pts_nxt = pts_r | pes_hdr_pkg::ts_piece(q_cmd.pos[2:0], q_cmd.data);
          end else if (q_cmd.pos < pes_hdr_pkg::POS_END) begin
            dts_nxt = dts_r | pes_hdr_pkg::ts_piece(dts_pos[2:0], q_cmd.data);
          end
        end
        default: begin
        end
      endcase
      if (q_cmd.emit != pes_hdr_pkg::EMIT_NONE) begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.pts_value     = '0;
        out_data_nxt.dts_value     = '0;
        out_data_nxt.header_length = q_cmd.hl;
        unique case (q_cmd.emit)
          pes_hdr_pkg::EMIT_BAD: begin
            out_data_nxt.status        = pes_hdr_pkg::ST_BAD_MARK;
            out_data_nxt.header_length = '0;
          end
          pes_hdr_pkg::EMIT_TRUNC: begin
            out_data_nxt.status = pes_hdr_pkg::ST_TRUNC;
          end
          default: begin
            if (flags_nxt == pes_hdr_pkg::FLAGS_PTS_DTS) begin
              if (q_cmd.hl < pes_hdr_pkg::HL_MIN_PTS_DTS) begin
                out_data_nxt.status = pes_hdr_pkg::ST_TOO_SHORT;
              end else begin
                out_data_nxt.status    = pes_hdr_pkg::ST_OK;
                out_data_nxt.pts_value = pts_nxt;
                out_data_nxt.dts_value = dts_nxt;
              end
            end else if (flags_nxt == pes_hdr_pkg::FLAGS_PTS) begin
              if (q_cmd.hl < pes_hdr_pkg::HL_MIN_PTS) begin
                out_data_nxt.status = pes_hdr_pkg::ST_TOO_SHORT;
              end else begin
                out_data_nxt.status    = pes_hdr_pkg::ST_OK;
                out_data_nxt.pts_value = pts_nxt;
                out_data_nxt.dts_value = pts_nxt;
              end
            end else begin
              out_data_nxt.status = pes_hdr_pkg::ST_NO_TS;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    pts_r      <= pts_nxt;
    dts_r      <= dts_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/pes_header_timestamp_parser_unit.sv]
// Top level: the PES optional-header timestamp parser.
// A header's closing byte queues a command; the back end then registers its result.
// Throughput: one byte per cycle; the input stalls only when the four-entry
// command queue is full, which happens only while the result register is held.
// Reset: synchronous active-low rst_n empties the queue and the result register
// and returns the parser to idle, waiting for a first byte.
`default_nettype none
`include "pes_header_timestamp_parser_unit_defines.svh"
module pes_header_timestamp_parser_unit (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  pes_hdr_pkg::in_beat_t   in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output pes_hdr_pkg::out_beat_t  out_data
);

  logic               in_accept;
  logic               cmd_valid;
  pes_hdr_pkg::cmd_t  front_cmd;
  pes_hdr_pkg::cmd_t  head_cmd;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  pes_hdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (front_cmd)
  );

  pes_hdr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept && cmd_valid),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  pes_hdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `PES_HDR_ASSERT_SAME(a_ok_has_room, clk, rst_n,
    out_valid && (out_data.status == pes_hdr_pkg::ST_OK),
    out_data.header_length >= pes_hdr_pkg::HL_MIN_PTS, "ok result with short header")
  `PES_HDR_ASSERT_SAME(a_bad_is_clean, clk, rst_n,
    out_valid && (out_data.status != pes_hdr_pkg::ST_OK),
    (out_data.pts_value == '0) && (out_data.dts_value == '0), "timestamps on failed header")
  `PES_HDR_ASSERT_SAME(a_bad_marker_no_len, clk, rst_n,
    out_valid && (out_data.status == pes_hdr_pkg::ST_BAD_MARK),
    out_data.header_length == '0, "bad marker with header length")
  `PES_HDR_ASSERT_NEXT(a_empty_no_stall, clk, rst_n,
    q_empty && !(in_accept && cmd_valid), !in_stall, "input stalled with empty queue")

endmodule
`default_nettype wire
